// ===== rtl/circular_queue_with_cancel_defines.svh =====
// ---------------------------------------------------------------------------
// circular_queue_with_cancel_defines.svh
// shared assertion macros for the ticket queue
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_WITH_CANCEL_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_CANCEL_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define CQC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("queue check failed");

// next-cycle implication, checked on every rising clock edge out of reset
`define CQC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("queue check failed");

`endif

// ===== rtl/cqc_pkg.sv =====
// ---------------------------------------------------------------------------
// cqc_pkg
// sizes, codes and control types shared by the ticket queue modules
// ---------------------------------------------------------------------------
`default_nettype none

package cqc_pkg;

	// queue sizing
	localparam int DEPTH      = 128;
	localparam int VALUE_BITS = 16;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// request codes
	localparam logic [1:0] ACT_PUSH   = 2'd0;
	localparam logic [1:0] ACT_POP    = 2'd1;
	localparam logic [1:0] ACT_CANCEL = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	// row-wide command from the controller
	typedef struct packed {
		logic                  shift;
		logic                  wr_en;
		logic [IDX_W-1:0]      wr_idx;
		logic [VALUE_BITS-1:0] wr_data;
	} row_ctl_t;

	// per-cell command
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/cqc_cell.sv =====
// ---------------------------------------------------------------------------
// cqc_cell
// one queue slot: holds, loads a new value, or takes its neighbor's value
// ---------------------------------------------------------------------------
`default_nettype none

module cqc_cell (
	input  wire logic                          clk,
	input  wire cqc_pkg::cell_ctl_t            ctl,
	input  wire logic [cqc_pkg::VALUE_BITS-1:0] load_data,
	input  wire logic [cqc_pkg::VALUE_BITS-1:0] next_data,
	output logic      [cqc_pkg::VALUE_BITS-1:0] data_q
);
	import cqc_pkg::*;

	// load wins over the shift toward the head
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= load_data;
		end else if (ctl.shift) begin
			data_q <= next_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cqc_ctrl.sv =====
// ---------------------------------------------------------------------------
// cqc_ctrl
// request sequencer: fill count, cancel rotation and result register
// ---------------------------------------------------------------------------
`default_nettype none
`include "circular_queue_with_cancel_defines.svh"

module cqc_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     action,
	input  wire logic [cqc_pkg::VALUE_BITS-1:0] item_value,
	input  wire logic [cqc_pkg::VALUE_BITS-1:0] head_data,
	output cqc_pkg::row_ctl_t                   row_ctl,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [1:0]                          status,
	output logic [cqc_pkg::VALUE_BITS-1:0]      popped_value,
	output logic                                empty_flag,
	output logic                                full_flag
);
	import cqc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_CANCEL = 2'b10
	} state_t;

	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	state_t                state_q, state_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [CNT_W-1:0]      steps_q, steps_d;
	logic                  found_q, found_d;
	logic [VALUE_BITS-1:0] target_q, target_d;
	logic                  out_valid_q, out_valid_d;
	logic [1:0]            status_q, status_d;
	logic [VALUE_BITS-1:0] popped_q, popped_d;
	logic                  out_load;
	logic                  out_free;
	logic                  accept;
	logic [CNT_W-1:0]      cnt_m1;
	logic                  is_match;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == S_IDLE) && out_free);
	assign accept   = in_valid && !in_stall;
	assign cnt_m1   = count_q - CNT_ONE;
	assign is_match = (head_data == target_q) && !found_q;

	// request decode and cancel rotation
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		steps_d     = steps_q;
		found_d     = found_q;
		target_d    = target_q;
		out_load    = 1'b0;
		status_d    = ST_OK;
		popped_d    = '0;
		row_ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					out_load = 1'b1;
					case (action)
						ACT_PUSH: begin
							if (count_q == CNT_FULL) begin
								status_d = ST_FULL;
							end else begin
								row_ctl.wr_en   = 1'b1;
								row_ctl.wr_idx  = count_q[IDX_W-1:0];
								row_ctl.wr_data = item_value;
								count_d         = count_q + CNT_ONE;
							end
						end
						ACT_POP: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								row_ctl.shift = 1'b1;
								popped_d      = head_data;
								count_d       = cnt_m1;
							end
						end
						ACT_CANCEL: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								out_load = 1'b0;
								target_d = item_value;
								steps_d  = count_q;
								found_d  = 1'b0;
								state_d  = S_CANCEL;
							end
						end
						default: begin
							status_d = ST_OK;
						end
					endcase
				end
			end
			S_CANCEL: begin
				if (steps_q != '0) begin
					// head leaves; it goes back in at the tail unless it is the first hit
					row_ctl.shift = 1'b1;
					steps_d       = steps_q - CNT_ONE;
					if (is_match) begin
						found_d = 1'b1;
						count_d = cnt_m1;
					end else begin
						row_ctl.wr_en   = 1'b1;
						row_ctl.wr_idx  = cnt_m1[IDX_W-1:0];
						row_ctl.wr_data = head_data;
					end
				end else if (out_free) begin
					out_load = 1'b1;
					status_d = found_q ? ST_OK : ST_MISSING;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// output register valid
	always_comb begin
		out_valid_d = out_valid_q;
		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			steps_q     <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			steps_q     <= steps_d;
			found_q     <= found_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		target_q <= target_d;
		if (out_load) begin
			status_q   <= status_d;
			popped_q   <= popped_d;
			empty_flag <= (count_d == '0);
			full_flag  <= (count_d == CNT_FULL);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign popped_value = popped_q;

	`CQC_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_FULL)
	`CQC_ASSERT_IMPL(a_stall_in_cancel, state_q == S_CANCEL, in_stall)
	`CQC_ASSERT_NEXT(a_cancel_step, state_q == S_CANCEL && steps_q != '0,
		count_q == $past(count_q) || count_q == $past(count_q) - CNT_ONE)
	`CQC_ASSERT_NEXT(a_found_once, state_q == S_CANCEL && found_q,
		found_q && count_q == $past(count_q))

endmodule

`default_nettype wire

// ===== rtl/circular_queue_with_cancel.sv =====
// ---------------------------------------------------------------------------
// circular_queue_with_cancel
// ticket queue with push, pop and cancel-by-value over a row of cells
// ---------------------------------------------------------------------------
// Entries sit in a row of DEPTH cells, oldest in cell zero. A push or a pop
// is finished at the edge that takes it, and its result is registered at that
// same edge, so back-to-back push/pop items go one per cycle while the result
// side keeps up. A cancel rotates the whole row through its head cell, one
// entry a cycle, dropping the first match and writing the rest back at the
// tail: it holds the input stalled until the rotation is done and its result
// is registered. There is no clearing pass after reset.
`default_nettype none

module circular_queue_with_cancel (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     action,
	input  wire logic [cqc_pkg::VALUE_BITS-1:0] item_value,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [1:0]                          status,
	output logic [cqc_pkg::VALUE_BITS-1:0]      popped_value,
	output logic                                empty_flag,
	output logic                                full_flag
);
	import cqc_pkg::*;

	row_ctl_t              row_ctl;
	logic [VALUE_BITS-1:0] cell_data [DEPTH];

	// sequencer
	cqc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.item_value   (item_value),
		.head_data    (cell_data[0]),
		.row_ctl      (row_ctl),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.popped_value (popped_value),
		.empty_flag   (empty_flag),
		.full_flag    (full_flag)
	);

	// cell row, each handing its value toward the head on a shift
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t             ctl;
		logic [VALUE_BITS-1:0] nxt;

		assign ctl.shift = row_ctl.shift;
		assign ctl.load  = row_ctl.wr_en && (row_ctl.wr_idx == IDX_W'(i));

		if (i == DEPTH - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end

		cqc_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.load_data (row_ctl.wr_data),
			.next_data (nxt),
			.data_q    (cell_data[i])
		);
	end

endmodule

`default_nettype wire

// ===== bench/circular_queue_with_cancel_tb.sv =====
// ---------------------------------------------------------------------------
// circular_queue_with_cancel_tb
// self-checking bench for the ticket queue with push, pop and cancel
// ---------------------------------------------------------------------------
// A behavioral copy of the queue, kept as a list of tickets, predicts each
// result when its item is taken. A monitor compares every result field by
// field. Directed cases come first: the edges of the value range, each
// action, and the empty, not-found and single-entry cases. A fill to
// full follows, then a long receiver hold-off, then random traffic that
// moves between growing and draining the queue.
// ---------------------------------------------------------------------------

module circular_queue_with_cancel_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cqc_pkg::*;

	// request code that leaves the queue unchanged
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam int HOLDOFF_CYCLES = 400;
	localparam int SETTLE_CYCLES  = 2 * DEPTH + 20;
	localparam int STALL_LIMIT    = 5000;

	typedef logic [VALUE_BITS-1:0] ticket_t;

	typedef struct packed {
		logic [1:0] status;
		ticket_t    popped;
		logic       empty;
		logic       full;
	} queue_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] action = ACT_PUSH;
	ticket_t    item_value = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] status;
	ticket_t    popped_value;
	logic       empty_flag;
	logic       full_flag;

	// predicted queue contents, oldest first, and results still to come
	ticket_t       ticket_line[$];
	queue_result_t expected_results[$];

	int failures = 0;
	int idle_cycles = 0;
	int holdoff_order = 0;
	int holdoff_taken = 0;
	int holdoff_left = 0;
	bit steady_mode = 1'b0;

	circular_queue_with_cancel dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.item_value  (item_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.popped_value(popped_value),
		.empty_flag  (empty_flag),
		.full_flag   (full_flag)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// queue behavior: apply one request and return its result
	function automatic queue_result_t apply_request(input logic [1:0] act, input ticket_t val);
		queue_result_t r;
		int hit;
		r.status = ST_OK;
		r.popped = '0;
		hit = -1;
		case (act)
			ACT_PUSH: begin
				if (ticket_line.size() == DEPTH)
					r.status = ST_FULL;
				else
					ticket_line.push_back(val);
			end
			ACT_POP: begin
				if (ticket_line.size() == 0)
					r.status = ST_EMPTY;
				else
					r.popped = ticket_line.pop_front();
			end
			ACT_CANCEL: begin
				if (ticket_line.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// first match from the oldest entry
					for (int i = 0; i < ticket_line.size() && hit < 0; i++)
						if (ticket_line[i] == val)
							hit = i;
					if (hit < 0)
						r.status = ST_MISSING;
					else
						ticket_line.delete(hit);
				end
			end
			default: ;
		endcase
		r.empty = (ticket_line.size() == 0);
		r.full  = (ticket_line.size() == DEPTH);
		return r;
	endfunction

	// ticket value: mostly a small pool so cancels hit and duplicates occur
	function automatic ticket_t pick_ticket(input logic [1:0] act);
		int roll;
		roll = $urandom_range(0, 99);
		if (act == ACT_CANCEL && ticket_line.size() != 0 && roll < 70)
			return ticket_line[$urandom_range(0, ticket_line.size() - 1)];
		if (roll < 50)
			return ticket_t'($urandom_range(0, 15));
		if (roll < 58)
			return '0;
		if (roll < 66)
			return '1;
		return ticket_t'($urandom);
	endfunction

	// offer one item, hold it until taken, then outside steady mode sometimes drop valid
	task automatic send_item(input logic [1:0] act, input ticket_t val);
		in_valid   <= 1'b1;
		action     <= act;
		item_value <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_results.push_back(apply_request(act, val));
		if (!steady_mode && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// stop sending until every predicted result has arrived
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			failures++;
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				failures++;
				$display("%0t ns: unexpected result, expected none, got status %0d popped %0h",
					$time, status, popped_value);
			end else begin
				want = expected_results.pop_front();
				check_field("status", want.status, status);
				check_field("popped_value", want.popped, popped_value);
				check_field("empty_flag", want.empty, empty_flag);
				check_field("full_flag", want.full, full_flag);
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (holdoff_taken != holdoff_order) begin
			holdoff_taken <= holdoff_order;
			holdoff_left  <= HOLDOFF_CYCLES;
			out_stall     <= 1'b1;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
			out_stall    <= 1'b1;
		end else begin
			out_stall <= !steady_mode && ($urandom_range(0, 99) < 8);
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t ns: no progress, %0d results outstanding", $time,
					expected_results.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// edges of the range, each action and the corner cases
	task automatic test_directed_cases();
		send_item(ACT_POP, '1);
		send_item(ACT_CANCEL, '0);
		send_item(ACT_UNUSED, '0);
		send_item(ACT_PUSH, '0);
		send_item(ACT_CANCEL, '0);
		send_item(ACT_PUSH, '1);
		send_item(ACT_PUSH, '0);
		send_item(ACT_PUSH, ticket_t'(16'hAAAA));
		send_item(ACT_PUSH, '0);
		send_item(ACT_PUSH, ticket_t'(16'h5555));
		send_item(ACT_CANCEL, ticket_t'(16'h1234));
		send_item(ACT_CANCEL, '0);
		send_item(ACT_UNUSED, '1);
		send_item(ACT_POP, '0);
		send_item(ACT_POP, '1);
		send_item(ACT_CANCEL, ticket_t'(16'h5555));
		send_item(ACT_POP, '0);
		send_item(ACT_POP, '0);
		send_item(ACT_PUSH, ticket_t'(16'h8000));
		send_item(ACT_PUSH, ticket_t'(16'h0001));
		send_item(ACT_CANCEL, ticket_t'(16'h8000));
		send_item(ACT_POP, '0);
		send_item(ACT_CANCEL, ticket_t'(16'h0001));
	endtask

	// fill to full, refused pushes, cancels at both ends and in the middle
	task automatic test_full_queue();
		ticket_t v;
		for (int i = 0; i < DEPTH; i++) begin
			v = ticket_t'(i * 517 + 3);
			send_item(ACT_PUSH, v);
		end
		send_item(ACT_PUSH, '1);
		send_item(ACT_PUSH, '0);
		send_item(ACT_UNUSED, '0);
		send_item(ACT_CANCEL, ticket_line[0]);
		send_item(ACT_CANCEL, ticket_line[ticket_line.size() - 1]);
		send_item(ACT_PUSH, '1);
		send_item(ACT_PUSH, '0);
		send_item(ACT_PUSH, ticket_t'(16'h7777));
		send_item(ACT_CANCEL, ticket_line[DEPTH / 2]);
		send_item(ACT_CANCEL, ticket_t'(16'hFFFE));
		send_item(ACT_PUSH, '0);
		send_item(ACT_POP, '0);
		send_item(ACT_CANCEL, '1);
		while (ticket_line.size() != 0)
			send_item(ACT_POP, ticket_t'($urandom));
		send_item(ACT_POP, '0);
	endtask

	// one stretch of random requests with the given mix in percent
	task automatic run_random_phase(input int n_items, input int push_pct, input int pop_pct,
			input int cancel_pct);
		int roll;
		logic [1:0] act;
		repeat (n_items) begin
			roll = $urandom_range(0, 99);
			if (roll < push_pct)
				act = ACT_PUSH;
			else if (roll < push_pct + pop_pct)
				act = ACT_POP;
			else if (roll < push_pct + pop_pct + cancel_pct)
				act = ACT_CANCEL;
			else
				act = ACT_UNUSED;
			send_item(act, pick_ticket(act));
		end
	endtask

	// receiver held off while the sender keeps offering, then all results drained
	task automatic test_receiver_holdoff();
		holdoff_order++;
		run_random_phase(48, 55, 15, 27);
		wait_for_results();
		run_random_phase(20, 40, 30, 27);
		wait_for_results();
	endtask

	// alternate growing and draining, one phase with no idling at all
	task automatic test_random_traffic();
		for (int phase = 0; phase < 6; phase++) begin
			steady_mode = (phase == 2);
			if (phase % 2 == 0)
				run_random_phase(225, 72, 10, 15);
			else
				run_random_phase(225, 20, 52, 25);
		end
		steady_mode = 1'b0;
	endtask

	// reset, tests in turn, final verdict
	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_full_queue();
		test_receiver_holdoff();
		test_random_traffic();

		wait_for_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
